[hdl/assert_macros.svh]
// assertion macros used by the top-level rtl file of the switch debounce block
// no dependencies; include once per file that asserts
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define SDPL_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("sdpl assertion failed");

// condition that must never be true outside reset
`define SDPL_ASSERT_NEVER(name, clk, rst_n, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("sdpl forbidden condition seen");

`endif

[hdl/sdpl_pkg.sv]
// types and constants of the switch debounce and press latch block
// no dependencies; imported by sdpl_core and the top level
`default_nettype none

package sdpl_pkg;

  localparam int unsigned FIELD_W    = 21;
  localparam int unsigned OP_W       = 2;
  localparam int unsigned S_TDATA_W  = 48;
  localparam int unsigned M_TDATA_W  = 48;

  typedef enum logic [OP_W-1:0] {
    OP_TICK  = 2'd0,
    OP_POP   = 2'd1,
    OP_CHECK = 2'd2
  } op_e;

  typedef struct packed {
    logic [FIELD_W-1:0] query_mask;
    logic [FIELD_W-1:0] raw_sample;
    logic [OP_W-1:0]    operation;
  } item_t;

  typedef struct packed {
    logic               mask_hit;
    logic [FIELD_W-1:0] popped_press;
    logic [FIELD_W-1:0] debounced_levels;
  } result_t;

endpackage

`default_nettype wire

[hdl/switch_debounce_press_latch_unit.sv]
// Switch debounce and press latch. Each transfer on the slave side carries an
// operation in tuser: a sample tick (the debounced levels take the raw sample
// when it matches the previous tick's sample, rising edges set sticky press
// bits), a pop (returns and clears the lowest latched press as a one-hot
// value) or a check (clears every masked press at once if all are latched and
// reports a hit; an empty mask always hits). Code 3 changes nothing. Every
// item yields exactly one result transfer with the debounced levels. Two
// register stages: one input register, the bitwise update logic, one result
// register. A slave transfer is held in the input register and then in the
// result register before master tvalid rises. One item per cycle is
// sustained as long as the master side takes results. SWITCH_COUNT sets the
// width of the internal state; fields stay 21 bits wide, extra input bits
// are ignored.
// depends on sdpl_pkg, sdpl_core and assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

module switch_debounce_press_latch_unit #(
  parameter int unsigned SWITCH_COUNT = 21
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  // slave side
  input  wire                                s_axis_tvalid,
  output logic                               s_axis_tready,
  // [20:0] raw_sample, [41:21] query_mask, [47:42] zero
  input  wire  [sdpl_pkg::S_TDATA_W-1:0]     s_axis_tdata,
  // [1:0] operation
  input  wire  [sdpl_pkg::OP_W-1:0]          s_axis_tuser,
  // master side
  output logic                               m_axis_tvalid,
  input  wire                                m_axis_tready,
  // [20:0] debounced_levels, [41:21] popped_press, [42] mask_hit, [47:43] zero
  output logic [sdpl_pkg::M_TDATA_W-1:0]     m_axis_tdata
);
  import sdpl_pkg::*;

  // input register
  logic    in_valid_q, in_valid_d;
  item_t   item_q;
  // result register
  logic    out_valid_q, out_valid_d;
  result_t res_q;
  result_t res_w;

  logic s_xfer;
  logic advance;

  // the item in the input register moves on when the result register is
  // free or being emptied in this cycle
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign s_xfer        = s_axis_tvalid && s_axis_tready;

  assign in_valid_d  = s_xfer || (in_valid_q && !advance);
  assign out_valid_d = advance || (out_valid_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      item_q.operation  <= s_axis_tuser;
      item_q.raw_sample <= s_axis_tdata[FIELD_W-1:0];
      item_q.query_mask <= s_axis_tdata[2*FIELD_W-1:FIELD_W];
    end
    if (advance) begin
      res_q <= res_w;
    end
  end

  // state is committed at the same edge the result is captured
  sdpl_core #(
    .SwitchCount(SWITCH_COUNT)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (advance),
    .item_i  (item_q),
    .result_o(res_w)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = M_TDATA_W'({res_q.mask_hit, res_q.popped_press,
                                     res_q.debounced_levels});

  // a pop never returns more than one press
  `SDPL_ASSERT(a_pop_onehot, clk_i, rst_ni,
    m_axis_tvalid |-> $onehot0(m_axis_tdata[2*FIELD_W-1:FIELD_W]))
  // a result never carries both a popped press and a mask hit
  `SDPL_ASSERT_NEVER(a_pop_and_hit, clk_i, rst_ni,
    m_axis_tvalid && m_axis_tdata[2*FIELD_W] &&
    (m_axis_tdata[2*FIELD_W-1:FIELD_W] != '0))
  // both registers full and master stalled: no new transfer taken
  `SDPL_ASSERT(a_full_stall, clk_i, rst_ni,
    (in_valid_q && out_valid_q && !m_axis_tready) |-> !s_axis_tready)
  // a held result stays unchanged until taken
  `SDPL_ASSERT(a_result_hold, clk_i, rst_ni,
    (out_valid_q && !m_axis_tready) |=> (out_valid_q && $stable(res_q)))

endmodule

`default_nettype wire

[hdl/sdpl_core.sv]
// debounce, press latch state and per-item update logic
// depends on sdpl_pkg
`default_nettype none

module sdpl_core #(
  parameter int unsigned SwitchCount = 21
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              en_i,
  input  sdpl_pkg::item_t  item_i,
  output sdpl_pkg::result_t result_o
);
  import sdpl_pkg::*;

  logic [SwitchCount-1:0] prev_q, prev_d;
  logic [SwitchCount-1:0] stable_q, stable_d;
  logic [SwitchCount-1:0] latch_q, latch_d;
  logic [SwitchCount-1:0] raw_w, mask_w, popped_w;
  logic                   hit_w;

  // bits at or above the switch count are dropped
  assign raw_w  = SwitchCount'(item_i.raw_sample);
  assign mask_w = SwitchCount'(item_i.query_mask);

  always_comb begin
    prev_d   = prev_q;
    stable_d = stable_q;
    latch_d  = latch_q;
    popped_w = '0;
    hit_w    = 1'b0;
    unique case (op_e'(item_i.operation))
      OP_TICK: begin
        if (raw_w == prev_q) begin
          stable_d = raw_w;
        end
        prev_d  = raw_w;
        latch_d = latch_q | (stable_d & ~stable_q);
      end
      OP_POP: begin
        popped_w = latch_q & (~latch_q + SwitchCount'(1));
        latch_d  = latch_q & ~popped_w;
      end
      OP_CHECK: begin
        if ((mask_w & ~latch_q) == '0) begin
          latch_d = latch_q & ~mask_w;
          hit_w   = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q   <= '0;
      stable_q <= '0;
      latch_q  <= '0;
    end else if (en_i) begin
      prev_q   <= prev_d;
      stable_q <= stable_d;
      latch_q  <= latch_d;
    end
  end

  assign result_o.debounced_levels = FIELD_W'(stable_d);
  assign result_o.popped_press     = FIELD_W'(popped_w);
  assign result_o.mask_hit         = hit_w;

endmodule

`default_nettype wire
